>>> rtl/gha_pkg.sv
// Shared codes and control types for the generational handle allocator.
package gha_pkg;

    // Request opcodes
    localparam logic [2:0] OP_ADD        = 3'd0;
    localparam logic [2:0] OP_TOGGLE     = 3'd1;
    localparam logic [2:0] OP_REMOVE     = 3'd2;
    localparam logic [2:0] OP_GET_HANDLE = 3'd3;
    localparam logic [2:0] OP_GET_INDEX  = 3'd4;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_STALE  = 2'd1,
        ST_FULL   = 2'd2,
        ST_UNUSED = 2'd3
    } t_status;

    // Which fields the result carries
    typedef enum logic [2:0] {
        RES_ZERO,
        RES_NEW,
        RES_ECHO,
        RES_ENTRY,
        RES_TOGGLE,
        RES_REMOVE
    } t_res_sel;

    // How the addressed table entry is rewritten
    typedef enum logic [1:0] {
        WR_NONE,
        WR_ADD,
        WR_TOGGLE,
        WR_REMOVE
    } t_wr_kind;

    // Decision for one request, from the decoder to the datapath
    typedef struct packed {
        t_status  status;
        t_res_sel res_sel;
        t_wr_kind wr_kind;
        logic     take_pop;
        logic     take_new;
        logic     push;
        logic     bump_rev;
    } t_ctrl;

endpackage

>>> rtl/gha_if.sv
// Request and response channel interfaces of the handle allocator.
interface gha_req_if #(
    parameter int IDX_W  = 8,
    parameter int REV_W  = 16,
    parameter int DATA_W = 32
);
    logic              valid;
    logic              ready;
    logic [2:0]        opcode;
    logic [IDX_W-1:0]  slot_index;
    logic [REV_W-1:0]  handle_revision;
    logic              on_flag;
    logic [DATA_W-1:0] payload;

    modport source (
        output valid, opcode, slot_index, handle_revision, on_flag, payload,
        input  ready
    );
    modport sink (
        input  valid, opcode, slot_index, handle_revision, on_flag, payload,
        output ready
    );
endinterface

interface gha_rsp_if #(
    parameter int IDX_W  = 8,
    parameter int REV_W  = 16,
    parameter int DATA_W = 32
);
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [IDX_W-1:0]  out_index;
    logic [REV_W-1:0]  out_revision;
    logic              out_on;
    logic [DATA_W-1:0] out_payload;

    modport source (
        output valid, status, out_index, out_revision, out_on, out_payload,
        input  ready
    );
    modport sink (
        input  valid, status, out_index, out_revision, out_on, out_payload,
        output ready
    );
endinterface

>>> rtl/gha_decide.sv
// Request decoder: picks status, result fields and table/stack updates.
module gha_decide (
    input  logic          [2:0] i_opcode,
    input  logic                i_in_use,
    input  logic                i_rev_ok,
    input  logic                i_stack_nonempty,
    input  logic                i_hw_full,
    output gha_pkg::t_ctrl      o_ctrl
);
    import gha_pkg::*;

    always_comb begin
        o_ctrl          = '0;
        o_ctrl.status   = ST_OK;
        o_ctrl.res_sel  = RES_ZERO;
        o_ctrl.wr_kind  = WR_NONE;
        unique case (i_opcode)
            // allocate: free stack first, then the next unused slot
            OP_ADD: begin
                priority if (i_stack_nonempty) begin
                    o_ctrl.res_sel  = RES_NEW;
                    o_ctrl.wr_kind  = WR_ADD;
                    o_ctrl.take_pop = 1'b1;
                end else if (!i_hw_full) begin
                    o_ctrl.res_sel  = RES_NEW;
                    o_ctrl.wr_kind  = WR_ADD;
                    o_ctrl.take_new = 1'b1;
                end else begin
                    o_ctrl.status = ST_FULL;
                end
            end
            // handle and index operations
            OP_TOGGLE, OP_REMOVE, OP_GET_HANDLE, OP_GET_INDEX: begin
                priority if (!i_in_use) begin
                    o_ctrl.status  = ST_UNUSED;
                    o_ctrl.res_sel = RES_ECHO;
                end else if (i_opcode == OP_GET_INDEX) begin
                    o_ctrl.res_sel = RES_ENTRY;
                end else if (!i_rev_ok) begin
                    o_ctrl.status  = ST_STALE;
                    o_ctrl.res_sel = RES_ECHO;
                end else if (i_opcode == OP_TOGGLE) begin
                    o_ctrl.res_sel = RES_TOGGLE;
                    o_ctrl.wr_kind = WR_TOGGLE;
                end else if (i_opcode == OP_REMOVE) begin
                    o_ctrl.res_sel  = RES_REMOVE;
                    o_ctrl.wr_kind  = WR_REMOVE;
                    o_ctrl.push     = 1'b1;
                    o_ctrl.bump_rev = 1'b1;
                end else begin
                    o_ctrl.res_sel = RES_ENTRY;
                end
            end
            // unknown opcode: all-zero result, no change
            default: begin
                o_ctrl.res_sel = RES_ZERO;
            end
        endcase
    end

endmodule

>>> rtl/generational_handle_allocator_core.sv
// Generational handle allocator core: slot table, free-slot stack and revision counter.
// A request is registered in the execute stage, and its result then in the result register.
// Throughput: one request per cycle while the result is taken; slot table and free stack
// each do one read and one write per cycle, with write-to-read forwarding on the same slot.
// Reset: clears valids, high-water mark, free count and revision; table contents stay.
module generational_handle_allocator_core #(
    parameter int SLOTS      = 256,
    parameter int REV_WIDTH  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gha_req_if.sink    i_req,
    gha_rsp_if.source  o_rsp
);
    import gha_pkg::*;

    localparam int IDX_W   = $clog2(SLOTS);
    localparam int CNT_W   = IDX_W + 1;
    localparam int ENTRY_W = DATA_WIDTH + REV_WIDTH + 2;

    // request in execute stage
    logic                  r_b_valid;
    logic [2:0]            r_b_op;
    logic [IDX_W-1:0]      r_b_idx;
    logic [REV_WIDTH-1:0]  r_b_hrev;
    logic                  r_b_on;
    logic [DATA_WIDTH-1:0] r_b_data;

    // slot table {free, on, revision, data} and its read port
    logic [ENTRY_W-1:0]    r_ent_mem [SLOTS];
    logic [ENTRY_W-1:0]    r_ent_rd;
    logic                  r_ent_hit;
    logic [ENTRY_W-1:0]    r_ent_byp;

    // free-slot stack and its top-of-stack read port
    logic [IDX_W-1:0]      r_fs_mem [SLOTS];
    logic [IDX_W-1:0]      r_fs_rd;
    logic                  r_fs_hit;
    logic [IDX_W-1:0]      r_fs_byp;

    // allocator state
    logic [CNT_W-1:0]      r_high_water, n_high_water;
    logic [CNT_W-1:0]      r_free_count, n_free_count;
    logic [REV_WIDTH-1:0]  r_global_rev, n_global_rev;

    // result register
    logic                  r_out_valid;
    t_status               r_out_status, n_out_status;
    logic [IDX_W-1:0]      r_out_index, n_out_index;
    logic [REV_WIDTH-1:0]  r_out_rev, n_out_rev;
    logic                  r_out_on, n_out_on;
    logic [DATA_WIDTH-1:0] r_out_data, n_out_data;

    logic                  req_fire;
    logic                  b_fire;
    logic [ENTRY_W-1:0]    ent_word;
    logic [DATA_WIDTH-1:0] ent_data;
    logic [REV_WIDTH-1:0]  ent_rev;
    logic                  ent_on;
    logic                  ent_free;
    logic                  in_use;
    logic                  rev_ok;
    logic [IDX_W-1:0]      fs_top;
    logic [IDX_W-1:0]      alloc_slot;
    logic [REV_WIDTH-1:0]  rev_next;
    t_ctrl                 ctrl;
    logic                  push_ok;
    logic                  ent_we;
    logic [IDX_W-1:0]      ent_wa;
    logic [ENTRY_W-1:0]    ent_wd;
    logic                  fs_we;
    logic [IDX_W-1:0]      fs_wa;
    logic [CNT_W-1:0]      fs_ra_full;
    logic [IDX_W-1:0]      fs_ra;

    // handshakes: execute stage drains into the result register
    assign b_fire      = r_b_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_b_valid || b_fire;
    assign req_fire    = i_req.valid && i_req.ready;

    // hold the accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (req_fire) begin
            r_b_valid <= 1'b1;
        end else if (b_fire) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_b_op   <= i_req.opcode;
            r_b_idx  <= i_req.slot_index;
            r_b_hrev <= i_req.handle_revision;
            r_b_on   <= i_req.on_flag;
            r_b_data <= i_req.payload;
        end
    end

    // slot table: write from execute, read at the incoming index, capture forwarded word
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            r_ent_mem[ent_wa] <= ent_wd;
        end
        if (req_fire) begin
            r_ent_rd  <= r_ent_mem[i_req.slot_index];
            r_ent_hit <= ent_we && (ent_wa == i_req.slot_index);
            r_ent_byp <= ent_wd;
        end
    end

    // free stack: push from execute, read the next top every cycle
    always_ff @(posedge i_clk) begin
        if (fs_we) begin
            r_fs_mem[fs_wa] <= r_b_idx;
        end
        r_fs_rd  <= r_fs_mem[fs_ra];
        r_fs_hit <= fs_we && (fs_wa == fs_ra);
        r_fs_byp <= r_b_idx;
    end

    // unpack the entry seen by the request in execute
    assign ent_word = r_ent_hit ? r_ent_byp : r_ent_rd;
    assign ent_data = ent_word[DATA_WIDTH-1:0];
    assign ent_rev  = ent_word[DATA_WIDTH +: REV_WIDTH];
    assign ent_on   = ent_word[DATA_WIDTH + REV_WIDTH];
    assign ent_free = ent_word[ENTRY_W-1];

    assign in_use     = {1'b0, r_b_idx} < r_high_water;
    assign rev_ok     = (ent_rev == r_b_hrev) && !ent_free;
    assign fs_top     = r_fs_hit ? r_fs_byp : r_fs_rd;
    assign rev_next   = r_global_rev + 1'b1;

    gha_decide u_decide (
        .i_opcode         (r_b_op),
        .i_in_use         (in_use),
        .i_rev_ok         (rev_ok),
        .i_stack_nonempty (r_free_count != '0),
        .i_hw_full        (r_high_water == CNT_W'(SLOTS)),
        .o_ctrl           (ctrl)
    );

    assign alloc_slot = ctrl.take_pop ? fs_top : r_high_water[IDX_W-1:0];
    assign push_ok    = ctrl.push && (r_free_count != CNT_W'(SLOTS));

    // build the entry write
    assign ent_we = b_fire && (ctrl.wr_kind != WR_NONE);
    assign ent_wa = (ctrl.wr_kind == WR_ADD) ? alloc_slot : r_b_idx;

    always_comb begin
        unique case (ctrl.wr_kind)
            WR_ADD:    ent_wd = {1'b0, r_b_on, r_global_rev, r_b_data};
            WR_TOGGLE: ent_wd = {ent_free, r_b_on, ent_rev, ent_data};
            WR_REMOVE: ent_wd = {1'b1, 1'b0, rev_next, ent_data};
            default:   ent_wd = ent_word;
        endcase
    end

    assign fs_we = b_fire && push_ok;
    assign fs_wa = r_free_count[IDX_W-1:0];

    // advance counters
    always_comb begin
        n_free_count = r_free_count;
        n_high_water = r_high_water;
        n_global_rev = r_global_rev;
        if (b_fire) begin
            if (ctrl.take_pop) begin
                n_free_count = r_free_count - 1'b1;
            end else if (push_ok) begin
                n_free_count = r_free_count + 1'b1;
            end
            if (ctrl.take_new) begin
                n_high_water = r_high_water + 1'b1;
            end
            if (ctrl.bump_rev) begin
                n_global_rev = rev_next;
            end
        end
    end

    assign fs_ra_full = n_free_count - 1'b1;
    assign fs_ra      = fs_ra_full[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_count <= '0;
            r_high_water <= '0;
            r_global_rev <= '0;
        end else begin
            r_free_count <= n_free_count;
            r_high_water <= n_high_water;
            r_global_rev <= n_global_rev;
        end
    end

    // select result fields
    always_comb begin
        n_out_status = ctrl.status;
        unique case (ctrl.res_sel)
            RES_NEW: begin
                n_out_index = alloc_slot;
                n_out_rev   = r_global_rev;
                n_out_on    = r_b_on;
                n_out_data  = r_b_data;
            end
            RES_ECHO: begin
                n_out_index = r_b_idx;
                n_out_rev   = r_b_hrev;
                n_out_on    = 1'b0;
                n_out_data  = '0;
            end
            RES_ENTRY: begin
                n_out_index = r_b_idx;
                n_out_rev   = ent_rev;
                n_out_on    = ent_on;
                n_out_data  = ent_data;
            end
            RES_TOGGLE: begin
                n_out_index = r_b_idx;
                n_out_rev   = ent_rev;
                n_out_on    = r_b_on;
                n_out_data  = ent_data;
            end
            RES_REMOVE: begin
                n_out_index = r_b_idx;
                n_out_rev   = r_b_hrev;
                n_out_on    = 1'b0;
                n_out_data  = ent_data;
            end
            default: begin
                n_out_index = '0;
                n_out_rev   = '0;
                n_out_on    = 1'b0;
                n_out_data  = '0;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_fire) begin
            r_out_status <= n_out_status;
            r_out_index  <= n_out_index;
            r_out_rev    <= n_out_rev;
            r_out_on     <= n_out_on;
            r_out_data   <= n_out_data;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.out_index    = r_out_index;
    assign o_rsp.out_revision = r_out_rev;
    assign o_rsp.out_on       = r_out_on;
    assign o_rsp.out_payload  = r_out_data;

endmodule

>>> rtl/gha_checker.sv
// Port-level checks for the handle allocator core, bound to the top level.
module gha_checker #(
    parameter int IDX_W  = 8,
    parameter int REV_W  = 16,
    parameter int DATA_W = 32
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_rsp_valid,
    input logic              i_rsp_ready,
    input logic [1:0]        i_status,
    input logic [IDX_W-1:0]  i_index,
    input logic [REV_W-1:0]  i_revision,
    input logic              i_on,
    input logic [DATA_W-1:0] i_payload
);
    import gha_pkg::*;

    // stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_status) && $stable(i_index)
            && $stable(i_revision) && $stable(i_payload))
        else $error("result changed while stalled");

    // full table result carries no slot
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status == ST_FULL) |->
            (i_index == '0) && (i_revision == '0) && !i_on && (i_payload == '0))
        else $error("table-full result carries data");

    // stale or unused handle exposes no slot contents
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && ((i_status == ST_STALE) || (i_status == ST_UNUSED)) |->
            !i_on && (i_payload == '0))
        else $error("rejected handle leaked slot contents");

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid after reset");

endmodule

bind generational_handle_allocator_core gha_checker #(
    .IDX_W  (IDX_W),
    .REV_W  (REV_WIDTH),
    .DATA_W (DATA_WIDTH)
) u_gha_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_index     (o_rsp.out_index),
    .i_revision  (o_rsp.out_revision),
    .i_on        (o_rsp.out_on),
    .i_payload   (o_rsp.out_payload)
);

>>> test/tb_top.sv
// Testbench for the handle allocator core: directed and random requests against a table model.
`timescale 1ns / 100ps

module tb_top;
    import gha_pkg::*;

    localparam int SLOTS        = 256;
    localparam int IDX_W        = 8;
    localparam int REV_W        = 16;
    localparam int DATA_W       = 32;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 40;

    typedef struct {
        t_status           status;
        logic [IDX_W-1:0]  index;
        logic [REV_W-1:0]  revision;
        logic              on;
        logic [DATA_W-1:0] payload;
    } t_result;

    logic clk;
    logic rst_n;

    gha_req_if #(.IDX_W(IDX_W), .REV_W(REV_W), .DATA_W(DATA_W)) req_if ();
    gha_rsp_if #(.IDX_W(IDX_W), .REV_W(REV_W), .DATA_W(DATA_W)) rsp_if ();

    generational_handle_allocator_core #(
        .SLOTS      (SLOTS),
        .REV_WIDTH  (REV_W),
        .DATA_WIDTH (DATA_W)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Slot table as the block should hold it
    logic [DATA_W-1:0] slot_payload  [SLOTS];
    logic [REV_W-1:0]  slot_revision [SLOTS];
    logic              slot_on       [SLOTS];
    logic              slot_free     [SLOTS];
    logic [IDX_W-1:0]  free_slots    [SLOTS];
    int unsigned       used_slots;
    int unsigned       free_depth;
    logic [REV_W-1:0]  live_revision;

    t_result expected_results [$];
    int      errors = 0;
    int      send_idle_pct = 19;
    int      recv_stall_pct = 46;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Apply one request to the slot table and return the result it must produce
    function automatic t_result apply_request(logic [2:0] op, logic [IDX_W-1:0] idx,
            logic [REV_W-1:0] hrev, logic on_in, logic [DATA_W-1:0] data);
        t_result          r;
        logic [IDX_W-1:0] slot;
        r = '{ST_OK, '0, '0, 1'b0, '0};
        if (op == OP_ADD) begin
            if (free_depth > 0) begin
                free_depth--;
                slot = free_slots[free_depth];
            end else if (used_slots < SLOTS) begin
                slot = used_slots[IDX_W-1:0];
                used_slots++;
            end else begin
                r.status = ST_FULL;
                return r;
            end
            slot_payload[slot]  = data;
            slot_on[slot]       = on_in;
            slot_revision[slot] = live_revision;
            slot_free[slot]     = 1'b0;
            r = '{ST_OK, slot, live_revision, on_in, data};
        end else if (op > OP_GET_INDEX) begin
            // unknown opcode: all-zero result, nothing changes
        end else if (idx >= used_slots) begin
            r = '{ST_UNUSED, idx, hrev, 1'b0, '0};
        end else if (op == OP_GET_INDEX) begin
            r = '{ST_OK, idx, slot_revision[idx], slot_on[idx], slot_payload[idx]};
        end else if (slot_revision[idx] != hrev || slot_free[idx]) begin
            r = '{ST_STALE, idx, hrev, 1'b0, '0};
        end else if (op == OP_REMOVE) begin
            // bump the revision, re-stamp the slot and push it on the free stack
            live_revision++;
            slot_on[idx]       = 1'b0;
            slot_revision[idx] = live_revision;
            slot_free[idx]     = 1'b1;
            free_slots[free_depth] = idx;
            free_depth++;
            r = '{ST_OK, idx, hrev, 1'b0, slot_payload[idx]};
        end else begin
            if (op == OP_TOGGLE)
                slot_on[idx] = on_in;
            r = '{ST_OK, idx, slot_revision[idx], slot_on[idx], slot_payload[idx]};
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // Compare each taken result with the oldest expectation
    always @(posedge clk) begin
        t_result want;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result: expected none, actual status %0h index %0h",
                             $time, rsp_if.status, rsp_if.out_index);
            end else begin
                want = expected_results.pop_front();
                check_field("status",   32'(rsp_if.status),       32'(want.status));
                check_field("index",    32'(rsp_if.out_index),    32'(want.index));
                check_field("revision", 32'(rsp_if.out_revision), 32'(want.revision));
                check_field("on",       32'(rsp_if.out_on),       32'(want.on));
                check_field("payload",  rsp_if.out_payload,       want.payload);
            end
        end
    end

    // Stall the response side at random
    always @(negedge clk) begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Drive one request, hold it until taken, then record its result
    task automatic send_request(logic [2:0] op, logic [IDX_W-1:0] idx,
            logic [REV_W-1:0] hrev, logic on_in, logic [DATA_W-1:0] data);
        t_result want;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid           <= 1'b1;
        req_if.opcode          <= op;
        req_if.slot_index      <= idx;
        req_if.handle_revision <= hrev;
        req_if.on_flag         <= on_in;
        req_if.payload         <= data;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        want = apply_request(op, idx, hrev, on_in, data);
        expected_results.insert(expected_results.size(), want);
    endtask

    // Drop valid and let every outstanding result come back
    task automatic wait_for_results();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // One random request, mostly on handles that are live in the table
    task automatic send_random(int add_pct, int remove_pct);
        int               pick;
        logic [2:0]       op;
        logic [IDX_W-1:0] idx;
        logic [REV_W-1:0] hrev;
        pick = $urandom_range(99);
        if (pick < add_pct)
            op = OP_ADD;
        else if (pick < add_pct + remove_pct)
            op = OP_REMOVE;
        else begin
            case ($urandom_range(9))
                0, 1, 2: op = OP_TOGGLE;
                3, 4, 5: op = OP_GET_HANDLE;
                6, 7, 8: op = OP_GET_INDEX;
                default: op = 3'($urandom_range(5, 7));
            endcase
        end
        if (used_slots > 0 && $urandom_range(99) < 85) begin
            idx = IDX_W'($urandom_range(used_slots - 1));
            for (int k = 0; k < 4 && slot_free[idx]; k++)
                idx = IDX_W'($urandom_range(used_slots - 1));
            hrev = slot_revision[idx];
            if ($urandom_range(9) == 0)
                hrev ^= REV_W'(1) << $urandom_range(REV_W - 1);
        end else begin
            idx  = IDX_W'($urandom);
            hrev = REV_W'($urandom);
        end
        send_request(op, idx, hrev, 1'($urandom), $urandom);
    endtask

    // Edges of the fields, each opcode, stale and never-allocated handles, LIFO reuse
    task automatic test_directed();
        send_request(OP_GET_INDEX,  8'h00, 16'h0000, 1'b0, 32'h0);
        send_request(OP_TOGGLE,     8'hFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
        send_request(3'd5,          8'hFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
        send_request(3'd6,          8'h55, 16'hAAAA, 1'b0, 32'h1234_5678);
        send_request(3'd7,          8'hFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
        send_request(OP_ADD,        8'hFF, 16'hFFFF, 1'b0, 32'h0000_0000);
        send_request(OP_ADD,        8'h00, 16'h0000, 1'b1, 32'hFFFF_FFFF);
        send_request(OP_ADD,        8'h00, 16'h0000, 1'b1, 32'hA5A5_5A5A);
        send_request(OP_TOGGLE,     8'h01, 16'h0000, 1'b0, 32'h0);
        send_request(OP_TOGGLE,     8'h00, 16'h0000, 1'b1, 32'h0);
        send_request(OP_GET_HANDLE, 8'h02, 16'h0000, 1'b0, 32'h0);
        send_request(OP_GET_HANDLE, 8'h02, 16'hFFFF, 1'b1, 32'h0);
        send_request(OP_REMOVE,     8'h01, 16'h0000, 1'b0, 32'h0);
        // remove again with the old and with the re-stamped revision
        send_request(OP_REMOVE,     8'h01, 16'h0000, 1'b0, 32'h0);
        send_request(OP_REMOVE,     8'h01, 16'h0001, 1'b0, 32'h0);
        send_request(OP_GET_HANDLE, 8'h01, 16'h0001, 1'b0, 32'h0);
        send_request(OP_TOGGLE,     8'h01, 16'h0001, 1'b1, 32'h0);
        send_request(OP_GET_INDEX,  8'h01, 16'hFFFF, 1'b0, 32'h0);
        send_request(OP_REMOVE,     8'h00, 16'h0000, 1'b0, 32'h0);
        // reuse freed slots last-in first-out, then a fresh one
        send_request(OP_ADD,        8'h00, 16'h0000, 1'b1, 32'h8000_0001);
        send_request(OP_ADD,        8'h00, 16'h0000, 1'b0, 32'h7FFF_FFFE);
        send_request(OP_ADD,        8'h00, 16'h0000, 1'b1, 32'hDEAD_BEEF);
        send_request(OP_GET_INDEX,  8'h03, 16'h0000, 1'b1, 32'h0);
        send_request(OP_GET_INDEX,  8'h04, 16'h0000, 1'b0, 32'h0);
    endtask

    task automatic test_random(int count, int add_pct, int remove_pct);
        repeat (count) send_random(add_pct, remove_pct);
    endtask

    // Fill every slot, add into a full table, then free and refill some
    task automatic test_table_full();
        logic [IDX_W-1:0] idx;
        while (used_slots < SLOTS || free_depth > 0)
            send_request(OP_ADD, IDX_W'($urandom), REV_W'($urandom), 1'($urandom), $urandom);
        repeat (3)
            send_request(OP_ADD, IDX_W'($urandom), REV_W'($urandom), 1'($urandom), $urandom);
        send_request(OP_GET_INDEX, 8'hFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
        repeat (40) begin
            idx = IDX_W'($urandom);
            send_request(OP_REMOVE, idx, slot_revision[idx], 1'b0, $urandom);
        end
        repeat (20)
            send_request(OP_ADD, IDX_W'($urandom), REV_W'($urandom), 1'($urandom), $urandom);
    endtask

    initial begin
        req_if.valid           = 1'b0;
        req_if.opcode          = OP_ADD;
        req_if.slot_index      = '0;
        req_if.handle_revision = '0;
        req_if.on_flag         = 1'b0;
        req_if.payload         = '0;
        rst_n                  = 1'b0;
        used_slots             = 0;
        free_depth             = 0;
        live_revision          = '0;
        for (int k = 0; k < SLOTS; k++)
            slot_free[k] = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct  = 19;
        recv_stall_pct = 46;
        test_directed();
        test_random(200, 40, 20);
        wait_for_results();

        send_idle_pct  = 46;
        recv_stall_pct = 19;
        test_table_full();
        test_random(200, 30, 30);
        wait_for_results();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random(200, 35, 25);
        wait_for_results();

        if (errors == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Hard stop well past the slowest correct run
    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
